/* rtl/hmg_pkg.sv */
package hmg_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam int ELEV_W        = 32;
    localparam int SLOPE_W       = 32;
    localparam int CELL_COL_W    = 10;
    localparam int CELL_ROW_W    = 12;
    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 13;
    localparam int INV_W         = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;

    localparam int MAG_W      = ELEV_W;
    localparam int PROD_W     = MAG_W + INV_W;
    localparam int SHIFT_FULL = 20;
    localparam int SHIFT_HALF = 21;
    localparam int Q_W        = PROD_W - SHIFT_FULL;

    localparam int JOBS = 4;

    localparam int RESET_GRID_WIDTH  = 1024;
    localparam int RESET_GRID_HEIGHT = 4096;
    localparam int RESET_COL_LAST =
        (RESET_GRID_WIDTH > MAX_WIDTH ? MAX_WIDTH : RESET_GRID_WIDTH) - 1;
    localparam int RESET_ROW_LAST =
        (RESET_GRID_HEIGHT > MAX_HEIGHT ? MAX_HEIGHT : RESET_GRID_HEIGHT) - 1;
    localparam logic [INV_W-1:0] RESET_INV_SPACING = 32'h0100_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT,
        REG_INV_SPACING_U,
        REG_INV_SPACING_V
    } cfg_reg_t;

    // cells finished by one sample, in output order
    typedef enum logic [1:0] {
        JOB_PREV_ROW,
        JOB_PREV_ROW_END,
        JOB_LAST_ROW,
        JOB_LAST_ROW_END
    } job_kind_t;

    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
        logic             restart;
    } geom_t;

    typedef struct packed {
        logic             neg_u;
        logic             full_u;
        logic             neg_v;
        logic             full_v;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag_u;
        logic [MAG_W-1:0] mag_v;
        tag_t             tag;
    } job_t;

endpackage

/* rtl/hmg_elev_if.sv */
interface hmg_elev_if;

    logic                               valid;
    logic                               ready;
    logic signed [hmg_pkg::ELEV_W-1:0] elevation;

    modport source (output valid, output elevation, input ready);
    modport sink (input valid, input elevation, output ready);

endinterface

/* rtl/hmg_grad_if.sv */
interface hmg_grad_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [hmg_pkg::SLOPE_W-1:0]   slope_u;
    logic signed [hmg_pkg::SLOPE_W-1:0]   slope_v;
    logic        [hmg_pkg::CELL_COL_W-1:0] cell_col;
    logic        [hmg_pkg::CELL_ROW_W-1:0] cell_row;
    logic                                 clipped;
    logic                                 run_last;

    modport source (
        output valid, output slope_u, output slope_v, output cell_col,
        output cell_row, output clipped, output run_last, input ready
    );
    modport sink (
        input valid, input slope_u, input slope_v, input cell_col,
        input cell_row, input clipped, input run_last, output ready
    );

endinterface

/* rtl/hmg_ram.sv */
module hmg_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/hmg_stencil.sv */
module hmg_stencil (
    input  logic               clk,
    input  logic               rst_n,
    input  hmg_pkg::geom_t     geom,
    hmg_elev_if.sink           samples,
    output logic               job_valid,
    output hmg_pkg::job_t      job,
    input  logic               job_ready
);

    function automatic logic [hmg_pkg::MAG_W:0] abs_diff(
        input logic [hmg_pkg::ELEV_W-1:0] a,
        input logic [hmg_pkg::ELEV_W-1:0] b
    );
        logic [hmg_pkg::ELEV_W:0] d_ab;
        logic [hmg_pkg::ELEV_W:0] d_ba;
        logic                     neg;
        d_ab = {a[hmg_pkg::ELEV_W-1], a} - {b[hmg_pkg::ELEV_W-1], b};
        d_ba = {b[hmg_pkg::ELEV_W-1], b} - {a[hmg_pkg::ELEV_W-1], a};
        neg  = d_ab[hmg_pkg::ELEV_W];
        return {neg, neg ? d_ba[hmg_pkg::MAG_W-1:0] : d_ab[hmg_pkg::MAG_W-1:0]};
    endfunction

    logic                        accept;
    logic [hmg_pkg::COL_W-1:0]   col_reg;
    logic [hmg_pkg::ROW_W-1:0]   row_reg;

    logic                        s1_valid_reg;
    logic [hmg_pkg::JOBS-1:0]    pend_reg;
    logic [hmg_pkg::JOBS-1:0]    pend_next;
    logic [hmg_pkg::ELEV_W-1:0]  x_reg;
    logic [hmg_pkg::COL_W-1:0]   s1_col_reg;
    logic [hmg_pkg::ROW_W-1:0]   s1_row_reg;
    logic                        c_pos_reg;
    logic                        c_one_reg;
    logic                        r_pos_reg;
    logic                        r_one_reg;
    logic                        r_odd_reg;

    logic [hmg_pkg::ELEV_W-1:0]  prev_m1_reg;
    logic [hmg_pkg::ELEV_W-1:0]  prev_m2_reg;
    logic [hmg_pkg::ELEV_W-1:0]  up_m1_reg;
    logic [hmg_pkg::ELEV_W-1:0]  cur_m1_reg;
    logic [hmg_pkg::ELEV_W-1:0]  cur_m2_reg;

    logic [hmg_pkg::ELEV_W-1:0]  even_rdata;
    logic [hmg_pkg::ELEV_W-1:0]  odd_rdata;
    logic [hmg_pkg::ELEV_W-1:0]  p0;
    logic [hmg_pkg::ELEV_W-1:0]  u0;

    logic                        c_pos;
    logic                        c_end;
    logic                        r_pos;
    logic                        r_end;
    logic [hmg_pkg::JOBS-1:0]    mask_new;

    hmg_pkg::job_kind_t          kind;
    logic [hmg_pkg::JOBS-1:0]    kind_bit;
    logic                        issue;
    logic                        retire;
    logic                        job_free;

    logic [hmg_pkg::ELEV_W-1:0]  opd_right;
    logic [hmg_pkg::ELEV_W-1:0]  opd_left;
    logic [hmg_pkg::ELEV_W-1:0]  opd_down;
    logic [hmg_pkg::ELEV_W-1:0]  opd_up;
    logic                        full_u;
    logic                        full_v;
    logic [hmg_pkg::COL_W-1:0]   cell_col;
    logic [hmg_pkg::ROW_W-1:0]   cell_row;
    logic [hmg_pkg::MAG_W:0]     diff_u;
    logic [hmg_pkg::MAG_W:0]     diff_v;

    logic                        job_valid_reg;
    hmg_pkg::job_t               job_reg;
    hmg_pkg::job_t               job_next;

    assign accept = samples.valid && samples.ready;

    // two line buffers picked by row parity, read and written at the same column
    hmg_ram #(
        .DATA_W (hmg_pkg::ELEV_W),
        .DEPTH  (hmg_pkg::MAX_WIDTH)
    ) u_ram_even (
        .clk     (clk),
        .wr_en   (accept && !row_reg[0]),
        .wr_addr (col_reg),
        .wr_data (samples.elevation),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (even_rdata)
    );

    hmg_ram #(
        .DATA_W (hmg_pkg::ELEV_W),
        .DEPTH  (hmg_pkg::MAX_WIDTH)
    ) u_ram_odd (
        .clk     (clk),
        .wr_en   (accept && row_reg[0]),
        .wr_addr (col_reg),
        .wr_data (samples.elevation),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (odd_rdata)
    );

    // raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (geom.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == geom.col_last)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == geom.row_last) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    assign c_pos = (col_reg != '0);
    assign c_end = (col_reg == geom.col_last);
    assign r_pos = (row_reg != '0);
    assign r_end = (row_reg == geom.row_last);

    always_comb
    begin
        mask_new = '0;
        mask_new[hmg_pkg::JOB_PREV_ROW]     = r_pos && c_pos;
        mask_new[hmg_pkg::JOB_PREV_ROW_END] = r_pos && c_end;
        mask_new[hmg_pkg::JOB_LAST_ROW]     = r_end && c_pos;
        mask_new[hmg_pkg::JOB_LAST_ROW_END] = r_end && c_end;
    end

    assign p0 = r_odd_reg ? even_rdata : odd_rdata;
    assign u0 = r_odd_reg ? odd_rdata : even_rdata;

    always_comb
    begin
        if (pend_reg[hmg_pkg::JOB_PREV_ROW])
        begin
            kind = hmg_pkg::JOB_PREV_ROW;
        end
        else if (pend_reg[hmg_pkg::JOB_PREV_ROW_END])
        begin
            kind = hmg_pkg::JOB_PREV_ROW_END;
        end
        else if (pend_reg[hmg_pkg::JOB_LAST_ROW])
        begin
            kind = hmg_pkg::JOB_LAST_ROW;
        end
        else
        begin
            kind = hmg_pkg::JOB_LAST_ROW_END;
        end
        kind_bit       = '0;
        kind_bit[kind] = 1'b1;
    end

    assign pend_next     = pend_reg & ~kind_bit;
    assign job_free      = !job_valid_reg || job_ready;
    assign issue         = s1_valid_reg && (pend_reg != '0) && job_free;
    assign retire        = s1_valid_reg && ((pend_reg == '0) || (issue && (pend_next == '0)));
    assign samples.ready = !s1_valid_reg || retire;

    // edge cells fall back to the cell itself on the missing side
    always_comb
    begin
        unique case (kind)
            hmg_pkg::JOB_PREV_ROW:
            begin
                opd_right = p0;
                opd_left  = c_one_reg ? prev_m1_reg : prev_m2_reg;
                full_u    = c_one_reg;
                opd_down  = cur_m1_reg;
                opd_up    = r_one_reg ? prev_m1_reg : up_m1_reg;
                full_v    = r_one_reg;
                cell_col  = s1_col_reg - 1'b1;
                cell_row  = s1_row_reg - 1'b1;
            end
            hmg_pkg::JOB_PREV_ROW_END:
            begin
                opd_right = p0;
                opd_left  = c_pos_reg ? prev_m1_reg : p0;
                full_u    = 1'b1;
                opd_down  = x_reg;
                opd_up    = r_one_reg ? p0 : u0;
                full_v    = r_one_reg;
                cell_col  = s1_col_reg;
                cell_row  = s1_row_reg - 1'b1;
            end
            hmg_pkg::JOB_LAST_ROW:
            begin
                opd_right = x_reg;
                opd_left  = c_one_reg ? cur_m1_reg : cur_m2_reg;
                full_u    = c_one_reg;
                opd_down  = cur_m1_reg;
                opd_up    = r_pos_reg ? prev_m1_reg : cur_m1_reg;
                full_v    = 1'b1;
                cell_col  = s1_col_reg - 1'b1;
                cell_row  = s1_row_reg;
            end
            hmg_pkg::JOB_LAST_ROW_END:
            begin
                opd_right = x_reg;
                opd_left  = c_pos_reg ? cur_m1_reg : x_reg;
                full_u    = 1'b1;
                opd_down  = x_reg;
                opd_up    = r_pos_reg ? p0 : x_reg;
                full_v    = 1'b1;
                cell_col  = s1_col_reg;
                cell_row  = s1_row_reg;
            end
            default:
            begin
                opd_right = x_reg;
                opd_left  = x_reg;
                full_u    = 1'b1;
                opd_down  = x_reg;
                opd_up    = x_reg;
                full_v    = 1'b1;
                cell_col  = s1_col_reg;
                cell_row  = s1_row_reg;
            end
        endcase
    end

    assign diff_u = abs_diff(opd_right, opd_left);
    assign diff_v = abs_diff(opd_down, opd_up);

    always_comb
    begin
        job_next            = '0;
        job_next.mag_u      = diff_u[hmg_pkg::MAG_W-1:0];
        job_next.mag_v      = diff_v[hmg_pkg::MAG_W-1:0];
        job_next.tag.neg_u  = diff_u[hmg_pkg::MAG_W];
        job_next.tag.full_u = full_u;
        job_next.tag.neg_v  = diff_v[hmg_pkg::MAG_W];
        job_next.tag.full_v = full_v;
        job_next.tag.col    = cell_col;
        job_next.tag.row    = cell_row;
        job_next.tag.last   = (pend_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pend_reg     <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            pend_reg     <= mask_new;
        end
        else
        begin
            if (issue)
            begin
                pend_reg <= pend_next;
            end
            if (retire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= samples.elevation;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
            c_pos_reg  <= c_pos;
            c_one_reg  <= (col_reg == hmg_pkg::COL_W'(1));
            r_pos_reg  <= r_pos;
            r_one_reg  <= (row_reg == hmg_pkg::ROW_W'(1));
            r_odd_reg  <= row_reg[0];
        end
    end

    // stencil window slides once per retired sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_m1_reg <= '0;
            prev_m2_reg <= '0;
            up_m1_reg   <= '0;
            cur_m1_reg  <= '0;
            cur_m2_reg  <= '0;
        end
        else if (retire)
        begin
            prev_m2_reg <= prev_m1_reg;
            prev_m1_reg <= p0;
            up_m1_reg   <= u0;
            cur_m2_reg  <= cur_m1_reg;
            cur_m1_reg  <= x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            job_valid_reg <= 1'b1;
        end
        else if (job_ready)
        begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

/* rtl/hmg_scale.sv */
module hmg_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [hmg_pkg::INV_W-1:0]  inv_u,
    input  logic [hmg_pkg::INV_W-1:0]  inv_v,
    input  logic                       job_valid,
    input  hmg_pkg::job_t              job,
    output logic                       job_ready,
    hmg_grad_if.source                 results
);

    function automatic logic [hmg_pkg::PROD_W-1:0] round_bit(input logic full);
        logic [hmg_pkg::PROD_W-1:0] one;
        one = {{(hmg_pkg::PROD_W-1){1'b0}}, 1'b1};
        return full ? (one << (hmg_pkg::SHIFT_FULL - 1)) : (one << (hmg_pkg::SHIFT_HALF - 1));
    endfunction

    function automatic logic [hmg_pkg::Q_W-1:0] scale_down(
        input logic [hmg_pkg::PROD_W-1:0] sum,
        input logic                       full
    );
        return full ? sum[hmg_pkg::PROD_W-1:hmg_pkg::SHIFT_FULL]
                    : {1'b0, sum[hmg_pkg::PROD_W-1:hmg_pkg::SHIFT_HALF]};
    endfunction

    // {clip, slope}
    function automatic logic [hmg_pkg::SLOPE_W:0] saturate(
        input logic [hmg_pkg::Q_W-1:0] q,
        input logic                    neg
    );
        logic over_pos;
        logic over_neg;
        logic [hmg_pkg::SLOPE_W-1:0] val;
        over_pos = |q[hmg_pkg::Q_W-1:hmg_pkg::SLOPE_W-1];
        over_neg = (|q[hmg_pkg::Q_W-1:hmg_pkg::SLOPE_W])
                   || (q[hmg_pkg::SLOPE_W-1] && (|q[hmg_pkg::SLOPE_W-2:0]));
        val      = q[hmg_pkg::SLOPE_W-1:0];
        if (neg)
        begin
            return over_neg ? {1'b1, 1'b1, {(hmg_pkg::SLOPE_W-1){1'b0}}}
                            : {1'b0, (~val) + 1'b1};
        end
        return over_pos ? {1'b1, 1'b0, {(hmg_pkg::SLOPE_W-1){1'b1}}} : {1'b0, val};
    endfunction

    logic                          p_valid_reg;
    logic [hmg_pkg::PROD_W-1:0]    prod_u_reg;
    logic [hmg_pkg::PROD_W-1:0]    prod_v_reg;
    hmg_pkg::tag_t                 p_tag_reg;
    logic [hmg_pkg::PROD_W-1:0]    prod_u_next;
    logic [hmg_pkg::PROD_W-1:0]    prod_v_next;

    logic                          q_valid_reg;
    logic [hmg_pkg::Q_W-1:0]       q_u_reg;
    logic [hmg_pkg::Q_W-1:0]       q_v_reg;
    hmg_pkg::tag_t                 q_tag_reg;
    logic [hmg_pkg::Q_W-1:0]       q_u_next;
    logic [hmg_pkg::Q_W-1:0]       q_v_next;

    logic                          out_valid_reg;
    logic [hmg_pkg::SLOPE_W-1:0]   slope_u_reg;
    logic [hmg_pkg::SLOPE_W-1:0]   slope_v_reg;
    logic [hmg_pkg::COL_W-1:0]     col_reg;
    logic [hmg_pkg::ROW_W-1:0]     row_reg;
    logic                          clipped_reg;
    logic                          last_reg;
    logic [hmg_pkg::SLOPE_W:0]     sat_u;
    logic [hmg_pkg::SLOPE_W:0]     sat_v;

    logic                          out_free;
    logic                          q_free;
    logic                          p_free;

    assign out_free  = !out_valid_reg || results.ready;
    assign q_free    = !q_valid_reg || out_free;
    assign p_free    = !p_valid_reg || q_free;
    assign job_ready = p_free;

    assign prod_u_next = job.mag_u * inv_u;
    assign prod_v_next = job.mag_v * inv_v;

    assign q_u_next = scale_down(prod_u_reg + round_bit(p_tag_reg.full_u), p_tag_reg.full_u);
    assign q_v_next = scale_down(prod_v_reg + round_bit(p_tag_reg.full_v), p_tag_reg.full_v);

    assign sat_u = saturate(q_u_reg, q_tag_reg.neg_u);
    assign sat_v = saturate(q_v_reg, q_tag_reg.neg_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
            begin
                p_valid_reg <= job_valid;
            end
            if (q_free)
            begin
                q_valid_reg <= p_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= q_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free && job_valid)
        begin
            prod_u_reg <= prod_u_next;
            prod_v_reg <= prod_v_next;
            p_tag_reg  <= job.tag;
        end
        if (q_free && p_valid_reg)
        begin
            q_u_reg   <= q_u_next;
            q_v_reg   <= q_v_next;
            q_tag_reg <= p_tag_reg;
        end
        if (out_free && q_valid_reg)
        begin
            slope_u_reg <= sat_u[hmg_pkg::SLOPE_W-1:0];
            slope_v_reg <= sat_v[hmg_pkg::SLOPE_W-1:0];
            clipped_reg <= sat_u[hmg_pkg::SLOPE_W] || sat_v[hmg_pkg::SLOPE_W];
            col_reg     <= q_tag_reg.col;
            row_reg     <= q_tag_reg.row;
            last_reg    <= q_tag_reg.last;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.slope_u  = slope_u_reg;
    assign results.slope_v  = slope_v_reg;
    assign results.cell_col = hmg_pkg::CELL_COL_W'(col_reg);
    assign results.cell_row = hmg_pkg::CELL_ROW_W'(row_reg);
    assign results.clipped  = clipped_reg;
    assign results.run_last = last_reg;

endmodule

/* rtl/height_map_gradient.sv */
// Height map gradient over a streamed raster.
// samples: one signed Q20.12 elevation per transaction, row-major order.
// results: slope_u/slope_v in signed Q16.16 (saturated, clipped flags it),
//   with the cell's column and row; run_last marks the final result of a sample.
// Results trail the input by one row and one column; a sample gives zero to four
//   results (four for a frame's last sample on a grid of 2 x 2 or more); frames wrap.
// Configuration: cfg_we/cfg_index/cfg_data, write only while the block is idle.
//   A grid_width or grid_height write restarts the frame at row 0, column 0.
// Throughput: one sample per cycle unless results stall; a sample with several results
//   holds samples.ready low until the single result path (one multiplier pair) takes its last.
// Path: the results of a sample pass the line buffer read, stencil, multiply, round and
//   output registers, in that order.
// Two line-buffer memories of MAX_WIDTH words hold the previous two rows.
// Reset: position cleared, geometry 1024 x 4096, both spacings 1.0; the line
//   buffers are not cleared and need no clearing pass.
// Stall: while results.ready is low the output holds; samples are still taken
//   until the four internal stages are full.
module height_map_gradient (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hmg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hmg_pkg::CFG_DATA_W-1:0]   cfg_data,
    hmg_elev_if.sink                         samples,
    hmg_grad_if.source                       results
);

    logic [hmg_pkg::COL_W-1:0]          col_last_reg;
    logic [hmg_pkg::ROW_W-1:0]          row_last_reg;
    logic [hmg_pkg::INV_W-1:0]          inv_u_reg;
    logic [hmg_pkg::INV_W-1:0]          inv_v_reg;
    logic [hmg_pkg::COL_W-1:0]          col_last_next;
    logic [hmg_pkg::ROW_W-1:0]          row_last_next;
    logic [hmg_pkg::GRID_WIDTH_W-1:0]   width_val;
    logic [hmg_pkg::GRID_HEIGHT_W-1:0]  height_val;

    hmg_pkg::geom_t                     geom;
    logic                               job_valid;
    hmg_pkg::job_t                      job;
    logic                               job_ready;

    // clamp geometry to 1..max
    always_comb
    begin
        width_val  = cfg_data[hmg_pkg::GRID_WIDTH_W-1:0];
        height_val = cfg_data[hmg_pkg::GRID_HEIGHT_W-1:0];
        if (width_val == '0)
        begin
            col_last_next = '0;
        end
        else if (int'(width_val) > hmg_pkg::MAX_WIDTH)
        begin
            col_last_next = hmg_pkg::COL_W'(hmg_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            col_last_next = hmg_pkg::COL_W'(width_val - 1'b1);
        end
        if (height_val == '0)
        begin
            row_last_next = '0;
        end
        else if (int'(height_val) > hmg_pkg::MAX_HEIGHT)
        begin
            row_last_next = hmg_pkg::ROW_W'(hmg_pkg::MAX_HEIGHT - 1);
        end
        else
        begin
            row_last_next = hmg_pkg::ROW_W'(height_val - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= hmg_pkg::COL_W'(hmg_pkg::RESET_COL_LAST);
            row_last_reg <= hmg_pkg::ROW_W'(hmg_pkg::RESET_ROW_LAST);
            inv_u_reg    <= hmg_pkg::RESET_INV_SPACING;
            inv_v_reg    <= hmg_pkg::RESET_INV_SPACING;
        end
        else if (cfg_we)
        begin
            unique case (hmg_pkg::cfg_reg_t'(cfg_index))
                hmg_pkg::REG_GRID_WIDTH:    col_last_reg <= col_last_next;
                hmg_pkg::REG_GRID_HEIGHT:   row_last_reg <= row_last_next;
                hmg_pkg::REG_INV_SPACING_U: inv_u_reg    <= cfg_data[hmg_pkg::INV_W-1:0];
                hmg_pkg::REG_INV_SPACING_V: inv_v_reg    <= cfg_data[hmg_pkg::INV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign geom.col_last = col_last_reg;
    assign geom.row_last = row_last_reg;
    assign geom.restart  = cfg_we && ((cfg_index == hmg_pkg::REG_GRID_WIDTH)
                                      || (cfg_index == hmg_pkg::REG_GRID_HEIGHT));

    hmg_stencil u_stencil (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .samples   (samples),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    hmg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .inv_u     (inv_u_reg),
        .inv_v     (inv_v_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .results   (results)
    );

endmodule
